[sv/playfair_digraph_encryptor_top_defines.svh]
// Assertion macros used by the Playfair encryptor top level.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfde: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PFDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfde: next-cycle check failed");

`endif

[sv/pfde_pkg.sv]
// Types and constants shared by the Playfair encryptor modules.
package pfde_pkg;

  localparam int SQ_SIDE  = 5;
  localparam int SQ_CELLS = 25;
  localparam int ALPHA    = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;

  localparam letter_t LETTER_Q    = 5'd16;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LAST_LETTER = 5'd25;
  localparam cell_t   LAST_CELL   = 5'd24;
  localparam logic [2:0] LAST_COL = 3'd4;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [6:0] ASCII_A7      = 7'h41;

  typedef enum logic [2:0] {
    FN_KEY_START  = 3'd0,
    FN_KEY_CHAR   = 3'd1,
    FN_KEY_FINISH = 3'd2,
    FN_TEXT_CHAR  = 3'd3,
    FN_END_MSG    = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_POS_A,
    ST_POS_B,
    ST_RULE,
    ST_CELL2,
    ST_CELL_DONE,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic    sq_clr;
    logic    sq_we;
    cell_t   sq_waddr;
    letter_t sq_wdata;
    cell_t   sq_raddr;
    logic    pos_clr;
    logic    pos_we;
    letter_t pos_waddr;
    pos_t    pos_wdata;
    letter_t pos_raddr;
  } store_ctrl_t;

endpackage

[sv/pfde_if.sv]
// Valid/ready channel interfaces for the Playfair encryptor.
interface pfde_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

interface pfde_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_letter;
  logic       out_last;

  modport source (output valid, output out_letter, output out_last, input ready);
  modport sink   (input valid, input out_letter, input out_last, output ready);
endinterface

[sv/pfde_store.sv]
// Key square and letter position memories with per-entry valid bits.
module pfde_store (
  input  logic                  clk,
  input  logic                  rst,
  input  pfde_pkg::store_ctrl_t ctrl,
  output pfde_pkg::letter_t     sq_rdata,
  output pfde_pkg::pos_t        pos_rdata
);
  import pfde_pkg::*;

  letter_t             sq_mem [SQ_CELLS];
  logic [SQ_CELLS-1:0] sq_vld;
  letter_t             sq_q;
  logic                sq_vld_q;

  pos_t                pos_mem [ALPHA];
  logic [ALPHA-1:0]    pos_vld;
  pos_t                pos_q;
  logic                pos_vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else if (ctrl.sq_clr) begin
      sq_vld <= '0;
    end else if (ctrl.sq_we) begin
      sq_vld[ctrl.sq_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sq_we) begin
      sq_mem[ctrl.sq_waddr] <= ctrl.sq_wdata;
    end
    sq_q     <= sq_mem[ctrl.sq_raddr];
    sq_vld_q <= sq_vld[ctrl.sq_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_vld <= '0;
    end else if (ctrl.pos_clr) begin
      pos_vld <= '0;
    end else if (ctrl.pos_we) begin
      pos_vld[ctrl.pos_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pos_we) begin
      pos_mem[ctrl.pos_waddr] <= ctrl.pos_wdata;
    end
    pos_q     <= pos_mem[ctrl.pos_raddr];
    pos_vld_q <= pos_vld[ctrl.pos_raddr];
  end

  // Entries not written since reset or the last clear read as zero.
  assign sq_rdata  = sq_vld_q  ? sq_q  : '0;
  assign pos_rdata = pos_vld_q ? pos_q : '0;

endmodule

[sv/pfde_rule.sv]
// Playfair pair rule: maps two square positions to the two output cell indexes.
module pfde_rule (
  input  pfde_pkg::pos_t  pa,
  input  pfde_pkg::pos_t  pb,
  output pfde_pkg::cell_t idx1,
  output pfde_pkg::cell_t idx2
);
  import pfde_pkg::*;

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v >= LAST_COL) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic cell_t cell_of(input logic [2:0] r, input logic [2:0] c);
    return cell_t'({r, 2'b00}) + cell_t'(r) + cell_t'(c);
  endfunction

  logic [2:0] r1, c1, r2, c2;

  always_comb begin
    r1 = pa.row;
    c1 = pa.col;
    r2 = pb.row;
    c2 = pb.col;
    if (pa.row == pb.row) begin
      c1 = wrap_inc(pa.col);
      c2 = wrap_inc(pb.col);
    end else if (pa.col == pb.col) begin
      r1 = wrap_inc(pa.row);
      r2 = wrap_inc(pb.row);
    end else begin
      c1 = pb.col;
      c2 = pa.col;
    end
  end

  assign idx1 = cell_of(r1, c1);
  assign idx2 = cell_of(r2, c2);

endmodule

[sv/playfair_digraph_encryptor_top.sv]
// Top level of the Playfair digraph encryptor: sequencer, key state and output register.
//
//   channel | dir | fields             | meaning
//   req     | in  | func[2:0], ch[7:0] | key set-up commands and text characters
//   rsp     | out | out_letter, out_last | encrypted letters, out_last on the second
//
// Start key, key character and skipped characters are taken without leaving the idle state.
// Finish key walks the alphabet, then for each cell reads the square and writes the
// position map, through the single read port of each memory.
// A text transfer that completes a pair, or an end of message with a letter pending,
// runs the chain of single-port reads, two positions and then two cells, and then emits
// the two letters before the next req transfer can be taken.
// Reset is synchronous and clears the sequencer state, key state, output valid flag
// and memory valid bits; there is no clearing pass. A stalled rsp holds the sequencer
// in its emit states, while the last letter may wait in the output register as the
// next req transfer is taken.
module playfair_digraph_encryptor_top (
  input logic        clk,
  input logic        rst,
  pfde_req_if.sink   req,
  pfde_rsp_if.source rsp
);
  import pfde_pkg::*;
  `include "playfair_digraph_encryptor_top_defines.svh"

  state_t      state, state_next;
  store_ctrl_t sctl;
  letter_t     sq_rdata;
  pos_t        pos_rdata;
  cell_t       idx1, idx2;

  // Key state.
  logic [ALPHA-1:0] used;
  cell_t            fill;
  letter_t          pending_letter;
  logic             pending_valid;

  // Sequencer working registers.
  letter_t    scan;
  logic [2:0] map_row, map_col;
  letter_t    op_a, op_b;
  pos_t       pa;
  cell_t      idx2_q;
  letter_t    let1, let2;

  // Output register.
  logic       out_valid;
  logic [6:0] out_letter_q;
  logic       out_last_q;
  logic       out_load;
  logic [6:0] out_letter_d;
  logic       out_last_d;
  logic       slot_free;

  // Input decode.
  logic    accept;
  logic    letter_ok;
  letter_t letter;
  logic    fill_open;
  logic    key_place;
  logic    fill_place;
  logic    text_pair;
  logic    text_same;
  logic    end_pair;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign slot_free = !out_valid || rsp.ready;
  assign fill_open = (fill < cell_t'(SQ_CELLS));

  always_comb begin
    letter_ok = 1'b0;
    letter    = '0;
    if (req.ch >= ASCII_LOWER_A && req.ch <= ASCII_LOWER_Z) begin
      letter_ok = 1'b1;
      letter    = letter_t'(req.ch - ASCII_LOWER_A);
    end else if (req.ch >= ASCII_UPPER_A && req.ch <= ASCII_UPPER_Z) begin
      letter_ok = 1'b1;
      letter    = letter_t'(req.ch - ASCII_UPPER_A);
    end
  end

  // A key letter is placed only when it is new, not Q, and the square has room.
  assign key_place = letter_ok && (letter != LETTER_Q) && !used[letter] && fill_open;
  // During finish, the scanned letter is placed on the same terms.
  assign fill_place = (scan != LETTER_Q) && !used[scan] && fill_open;
  assign text_pair  = letter_ok && pending_valid;
  assign text_same  = text_pair && (letter == pending_letter);
  assign end_pair   = pending_valid;

  pfde_store u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctl),
    .sq_rdata  (sq_rdata),
    .pos_rdata (pos_rdata)
  );

  pfde_rule u_rule (
    .pa   (pa),
    .pb   (pos_rdata),
    .idx1 (idx1),
    .idx2 (idx2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port control and output load.
  always_comb begin
    state_next   = state;
    sctl         = '0;
    out_load     = 1'b0;
    out_letter_d = ASCII_A7 + 7'(let1);
    out_last_d   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(req.func))
            FN_KEY_START: begin
              sctl.sq_clr = 1'b1;
            end
            FN_KEY_CHAR: begin
              sctl.sq_we    = key_place;
              sctl.sq_waddr = fill;
              sctl.sq_wdata = letter;
            end
            FN_KEY_FINISH: begin
              state_next = ST_FILL;
            end
            FN_TEXT_CHAR: begin
              if (text_pair) begin
                state_next = ST_POS_A;
              end
            end
            FN_END_MSG: begin
              if (end_pair) begin
                state_next = ST_POS_A;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        sctl.sq_we    = fill_place;
        sctl.sq_waddr = fill;
        sctl.sq_wdata = scan;
        if (scan == LAST_LETTER) begin
          sctl.pos_clr = 1'b1;
          state_next   = ST_MAP_RD;
        end
      end
      ST_MAP_RD: begin
        sctl.sq_raddr = scan;
        state_next    = ST_MAP_WR;
      end
      ST_MAP_WR: begin
        sctl.pos_we    = 1'b1;
        sctl.pos_waddr = sq_rdata;
        sctl.pos_wdata = '{row: map_row, col: map_col};
        state_next     = (scan == LAST_CELL) ? ST_IDLE : ST_MAP_RD;
      end
      ST_POS_A: begin
        sctl.pos_raddr = op_a;
        state_next     = ST_POS_B;
      end
      ST_POS_B: begin
        sctl.pos_raddr = op_b;
        state_next     = ST_RULE;
      end
      ST_RULE: begin
        sctl.sq_raddr = idx1;
        state_next    = ST_CELL2;
      end
      ST_CELL2: begin
        sctl.sq_raddr = idx2_q;
        state_next    = ST_CELL_DONE;
      end
      ST_CELL_DONE: begin
        state_next = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        out_letter_d = ASCII_A7 + 7'(let2);
        out_last_d   = 1'b1;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Key state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= '0;
      fill           <= '0;
      pending_letter <= '0;
      pending_valid  <= 1'b0;
    end else if (state == ST_IDLE && accept) begin
      case (func_t'(req.func))
        FN_KEY_START: begin
          used           <= '0;
          fill           <= '0;
          pending_letter <= '0;
          pending_valid  <= 1'b0;
        end
        FN_KEY_CHAR: begin
          if (key_place) begin
            used[letter] <= 1'b1;
            fill         <= fill + cell_t'(1);
          end
        end
        FN_TEXT_CHAR: begin
          if (letter_ok && !pending_valid) begin
            pending_letter <= letter;
            pending_valid  <= 1'b1;
          end else if (text_pair && !text_same) begin
            pending_valid <= 1'b0;
          end
        end
        FN_END_MSG: begin
          pending_valid <= 1'b0;
        end
        default: begin
          pending_valid <= pending_valid;
        end
      endcase
    end else if (state == ST_FILL && fill_place) begin
      used[scan] <= 1'b1;
      fill       <= fill + cell_t'(1);
    end
  end

  // Sequencer working registers; the pair operands are loaded in every idle cycle.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        scan    <= '0;
        map_row <= '0;
        map_col <= '0;
        op_a    <= pending_letter;
        op_b    <= (text_pair && !text_same) ? letter : LETTER_X;
        if (func_t'(req.func) == FN_END_MSG) begin
          op_b <= LETTER_X;
        end
      end
      ST_FILL: begin
        scan <= (scan == LAST_LETTER) ? letter_t'(0) : scan + letter_t'(1);
      end
      ST_MAP_WR: begin
        scan <= scan + letter_t'(1);
        if (map_col == LAST_COL) begin
          map_col <= '0;
          map_row <= map_row + 3'd1;
        end else begin
          map_col <= map_col + 3'd1;
        end
      end
      ST_POS_B: begin
        pa <= pos_rdata;
      end
      ST_RULE: begin
        idx2_q <= idx2;
      end
      ST_CELL2: begin
        let1 <= sq_rdata;
      end
      ST_CELL_DONE: begin
        let2 <= sq_rdata;
      end
      default: begin
        scan <= scan;
      end
    endcase
  end

  // Output register: a held letter does not block the sequencer from loading
  // the next one in the cycle it transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_letter_q <= out_letter_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_letter = out_letter_q;
  assign rsp.out_last   = out_last_q;

  // The first letter of a pair is still held or just replaced while the second waits.
  `PFDE_ASSERT_NOW(a_emit2_holds_first, (state == ST_EMIT2), (rsp.valid && !rsp.out_last))
  // Ending a message always leaves nothing pending.
  `PFDE_ASSERT_NEXT(a_end_clears, (accept && req.func == FN_END_MSG), (!pending_valid))
  // Outside the fill walk, the square never overfills.
  `PFDE_ASSERT_NOW(a_fill_bound, (state != ST_FILL), (fill <= cell_t'(SQ_CELLS)))

endmodule
